// File: src/pwm_pkg.sv
// shared constants and types for the pick window majority id block
package pwm_pkg;

    localparam int ID_W           = 32;
    localparam int COUNT_W        = 7;
    localparam int MAX_PIXELS_DEF = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef struct packed {
        logic valid;
        logic take;
        logic alloc;
    } cell_ctrl_t;

endpackage

// File: src/pwm_cell.sv
// one table entry: stored id, saturating hit count and id compare
module pwm_cell (
    input  logic                       clk,
    input  pwm_pkg::cell_ctrl_t        ctrl,
    input  logic [pwm_pkg::ID_W-1:0]   pixel_id,
    output logic                       match,
    output logic [pwm_pkg::COUNT_W-1:0] count_hit
);
    import pwm_pkg::*;

    logic [ID_W-1:0]    id_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_inc;

    assign match     = ctrl.valid && (id_reg == pixel_id);
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + COUNT_ONE;
    assign count_hit = match ? count_inc : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.take && match)
        begin
            count_reg <= count_inc;
        end
        else if (ctrl.take && ctrl.alloc)
        begin
            id_reg    <= pixel_id;
            count_reg <= COUNT_ONE;
        end
    end

endmodule

// File: src/pick_window_majority_id_core.sv
// top level: most frequent nonzero id over one pick window
//
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   s_tdata = pixel_id, s_tlast = last_pixel
// m_*      out  m_tvalid / m_tready   m_tdata = chosen_id, chosen_count
//
// one item per cycle while the pipe is not stalled; a result leaves once its last item
// has passed the input register, the s2 register and the result register; the table lookup,
// count update and slot allocation act on the input register, the best id compare and result load on s2
// reset empties the table and the best id at once, no clearing pass
// the pipe stalls only while a finished result waits and another is ready behind it
module pick_window_majority_id_core #(
    parameter int MAX_PIXELS = pwm_pkg::MAX_PIXELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pwm_pkg::ID_W-1:0]   s_tdata,   // pixel_id
    input  logic                       s_tlast,   // last_pixel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [39:0]                m_tdata    // chosen_id, chosen_count, zero pad
);
    import pwm_pkg::*;

    localparam int USED_W = $clog2(MAX_PIXELS + 1);

    logic                  in_valid_reg;
    logic                  in_last_reg;
    logic [ID_W-1:0]       in_id_reg;
    logic [USED_W-1:0]     used_reg;
    logic [USED_W-1:0]     used_next;
    logic                  s2_valid_reg;
    logic                  s2_last_reg;
    logic [ID_W-1:0]       s2_id_reg;
    logic [COUNT_W-1:0]    s2_count_reg;
    logic [ID_W-1:0]       best_id_reg;
    logic [COUNT_W-1:0]    best_count_reg;
    logic                  m_valid_reg;
    logic [ID_W-1:0]       m_id_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    logic                  out_free;
    logic                  adv;
    logic                  take;
    logic                  hit;
    logic                  alloc;
    logic                  upd;
    logic [COUNT_W-1:0]    sel_count;
    logic [MAX_PIXELS-1:0] match_vec;
    logic [COUNT_W-1:0]    count_vec [MAX_PIXELS];
    cell_ctrl_t            ctrl_vec  [MAX_PIXELS];

    assign out_free = !m_valid_reg || m_tready;
    assign adv      = out_free || !(s2_valid_reg && s2_last_reg);
    assign s_tready = adv;
    assign take     = adv && in_valid_reg && (in_id_reg != '0);
    assign hit      = |match_vec;
    assign alloc    = !hit && (used_reg < USED_W'(MAX_PIXELS));
    assign upd      = s2_count_reg > best_count_reg;

    genvar k;
    generate
        for (k = 0; k < MAX_PIXELS; k++)
        begin : g_cell
            assign ctrl_vec[k].valid = USED_W'(k) < used_reg;
            assign ctrl_vec[k].take  = take;
            assign ctrl_vec[k].alloc = alloc && (used_reg == USED_W'(k));

            pwm_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl_vec[k]),
                .pixel_id  (in_id_reg),
                .match     (match_vec[k]),
                .count_hit (count_vec[k])
            );
        end
    endgenerate

    always_comb
    begin
        sel_count = '0;
        for (int i = 0; i < MAX_PIXELS; i++)
        begin
            sel_count = sel_count | count_vec[i];
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (adv && in_valid_reg)
        begin
            if (in_last_reg)
            begin
                used_next = '0;
            end
            else if (take && alloc)
            begin
                used_next = used_reg + USED_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            used_reg       <= '0;
            s2_valid_reg   <= 1'b0;
            best_id_reg    <= '0;
            best_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (adv)
            begin
                in_valid_reg <= s_tvalid;
                s2_valid_reg <= in_valid_reg;
                if (s2_valid_reg)
                begin
                    if (s2_last_reg)
                    begin
                        best_id_reg    <= '0;
                        best_count_reg <= '0;
                    end
                    else if (upd)
                    begin
                        best_id_reg    <= s2_id_reg;
                        best_count_reg <= s2_count_reg;
                    end
                end
            end
            if (out_free)
            begin
                m_valid_reg <= s2_valid_reg && s2_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_id_reg    <= s_tdata;
            in_last_reg  <= s_tlast;
            s2_last_reg  <= in_last_reg;
            s2_id_reg    <= in_id_reg;
            s2_count_reg <= take ? (hit ? sel_count : (alloc ? COUNT_ONE : '0)) : '0;
        end
        if (out_free && s2_valid_reg && s2_last_reg)
        begin
            m_id_reg    <= upd ? s2_id_reg    : best_id_reg;
            m_count_reg <= upd ? s2_count_reg : best_count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_id_reg};

    // at most one table entry holds any id
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(match_vec))
        else $error("more than one table entry matched");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(MAX_PIXELS))
        else $error("entry count beyond table size");

    a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (best_count_reg == '0) == (best_id_reg == '0))
        else $error("best id and best count disagree on empty");

    a_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> ((m_count_reg == '0) == (m_id_reg == '0)))
        else $error("result id and count disagree on empty");

endmodule
